### sv/rpfh_pkg.sv
package rpfh_pkg;

  // Default vertex coordinate width in whole pixels.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Fixed widths of the ray fields.
  localparam int unsigned ORG_W  = 21;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned HIT_W  = 20;
  localparam int unsigned DIST_W = 22;

  // Saturated distance, also the value that stands for no hit yet.
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Unit length in Q1.14.
  localparam logic [14:0] Q14_ONE = 15'd16384;

  // Iteration counts of the square root and the shared divider.
  localparam logic [5:0] SQRT_STEPS  = 6'd30;
  localparam logic [5:0] NORM_QBITS  = 6'd15;
  localparam logic [5:0] DIST_QBITS  = 6'd22;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L2A,
    ST_L2B,
    ST_SQI,
    ST_SQRT,
    ST_NDX,
    ST_NDY,
    ST_DIV,
    ST_DFIN,
    ST_FDONE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_NEG,
    ST_TEST,
    ST_CMP,
    ST_HX,
    ST_HXW,
    ST_HY,
    ST_HYW,
    ST_EDONE,
    ST_OUT
  } rpfh_state_e;

  // Which result the divider is working on.
  typedef enum logic [1:0] {
    DIV_UX,
    DIV_UY,
    DIV_DIST
  } rpfh_div_tgt_e;

endpackage

### sv/rpfh_if.sv
// Vertex stream into the block.
interface rpfh_in_if import rpfh_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [COORD_BITS-1:0]    vertex_x;
  logic [COORD_BITS-1:0]    vertex_y;
  logic                     last_vertex;
  logic signed [ORG_W-1:0]  origin_x;
  logic signed [ORG_W-1:0]  origin_y;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;

  modport source (
    output valid, vertex_x, vertex_y, last_vertex, origin_x, origin_y, dir_x, dir_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, last_vertex, origin_x, origin_y, dir_x, dir_y,
    output ready
  );
endinterface

// Hit result out of the block.
interface rpfh_out_if import rpfh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [HIT_W-1:0]  hit_x;
  logic [HIT_W-1:0]  hit_y;
  logic [DIST_W-1:0] hit_distance;

  modport source (
    output valid, found, hit_x, hit_y, hit_distance,
    input  ready
  );
  modport sink (
    input  valid, found, hit_x, hit_y, hit_distance,
    output ready
  );
endinterface

### sv/ray_polygon_first_hit.sv
// Channel | Dir | Transaction
// in_i    | in  | one polygon vertex; ray origin and direction used on the first one
// out_o   | out | found flag, nearest hit point and distance, on the last vertex
//
// The first vertex of a polygon takes 2 multiplies, a 30-step square root and two
// 15-step divisions through the shared divider.
// A zero direction skips the square root and divisions.
// Each edge takes 6 multiplies on the shared multiplier; a hit edge adds a 22-step
// division, unless the distance saturates, and the hit point when it is the nearest yet.
// The last vertex adds the closing edge. in_i.ready is high only between items.
// Reset is asynchronous and active low. The result sits in an output register;
// a stalled out_o holds the block only when the next result is ready.
module ray_polygon_first_hit import rpfh_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpfh_in_if.sink     in_i,
  rpfh_out_if.source  out_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned EW   = CB + 1;
  localparam int unsigned RW   = (((CB + 8) > ORG_W) ? (CB + 8) : ORG_W) + 2;
  localparam int unsigned MAW  = (RW > 23) ? RW : 23;
  localparam int unsigned MBW  = (EW > 17) ? EW : 17;
  localparam int unsigned PW   = MAW + MBW;
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned DW   = AW + 1;
  localparam int unsigned CW   = AW + 8;
  localparam int          HMAX = (2 ** CB - 1) * 256;

  rpfh_state_e state_q, state_d;

  logic                    last_q, expect_first_q, closing_q, dir_valid_q;
  logic [CB-1:0]           first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [CB-1:0]           ax_q, ay_q, bx_q, by_q;
  logic signed [ORG_W-1:0] ox_q, oy_q;
  logic signed [DIR_W-1:0] dx_q, dy_q, ux_q, uy_q;
  logic signed [AW-1:0]    det_q, nt_q, nu_q;
  logic [59:0]             sq_s_q;
  logic [29:0]             sq_root_q;
  logic [33:0]             sq_rem_q;
  logic [5:0]              cnt_q;
  logic [DW-1:0]           dv_rem_q;
  logic [21:0]             dv_low_q, dv_quo_q;
  logic [AW-1:0]           dv_div_q;
  rpfh_div_tgt_e           dv_tgt_q;
  logic [DIST_W-1:0]       t_q, best_dist_q;
  logic signed [PW-1:0]    p_q;
  logic [HIT_W-1:0]        best_hx_q, best_hy_q;
  logic                    any_hit_q;
  logic                    out_valid_q, out_found_q;
  logic [HIT_W-1:0]        out_hx_q, out_hy_q;
  logic [DIST_W-1:0]       out_dist_q;

  logic                    in_ready;
  logic                    in_fire;
  logic                    out_load;

  // Edge vector in whole pixels and origin offset in 1/256 pixel.
  logic signed [EW-1:0] ex, ey;
  logic signed [RW-1:0] rx, ry;
  assign ex = $signed({1'b0, bx_q}) - $signed({1'b0, ax_q});
  assign ey = $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
  assign rx = $signed(RW'({ax_q, 8'h00})) - RW'(ox_q);
  assign ry = $signed(RW'({ay_q, 8'h00})) - RW'(oy_q);

  // Shared multiplier.
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  prod_w;
  assign prod   = mul_a * mul_b;
  assign prod_w = AW'(prod);

  // Square root step, one result bit per pass.
  logic [33:0] sq_rem_n, sq_trial;
  logic        sq_ge;
  assign sq_rem_n = {sq_rem_q[31:0], sq_s_q[59:58]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_rem_n >= sq_trial;

  // Restoring divider step, one quotient bit per pass.
  logic [DW-1:0] dv_rem_n, dv_sub;
  logic          dv_ge;
  assign dv_rem_n = {dv_rem_q[DW-2:0], dv_low_q[21]};
  assign dv_sub   = dv_rem_n - {1'b0, dv_div_q};
  assign dv_ge    = dv_rem_n >= {1'b0, dv_div_q};

  // Numerators of the normalization: |d| * 2^28 + root / 2.
  logic [16:0] mag_dx, mag_dy;
  logic [45:0] nx_num, ny_num;
  assign mag_dx = dx_q[DIR_W-1] ? 17'(-$signed({dx_q[DIR_W-1], dx_q}))
                                : {1'b0, dx_q};
  assign mag_dy = dy_q[DIR_W-1] ? 17'(-$signed({dy_q[DIR_W-1], dy_q}))
                                : {1'b0, dy_q};
  assign nx_num = {1'b0, mag_dx, 28'h0} + 46'(sq_root_q[29:1]);
  assign ny_num = {1'b0, mag_dy, 28'h0} + 46'(sq_root_q[29:1]);

  // Clamped and signed unit component from the divider quotient.
  logic [15:0]             uq_mag;
  logic signed [DIR_W-1:0] unit_pos;
  assign uq_mag   = (dv_quo_q[14:0] > Q14_ONE) ? {1'b0, Q14_ONE} : {1'b0, dv_quo_q[14:0]};
  assign unit_pos = $signed(uq_mag);

  // Hit tests on the sign-corrected determinant and numerators.
  logic [CW-1:0] nt_w, nu_w, det_w, nt64_w, det256_w;
  logic          edge_hit, dist_sat;
  assign nt_w     = CW'($unsigned(nt_q));
  assign nu_w     = CW'($unsigned(nu_q));
  assign det_w    = CW'($unsigned(det_q));
  assign nt64_w   = {2'b00, $unsigned(nt_q), 6'h00};
  assign det256_w = {$unsigned(det_q), 8'h00};
  assign edge_hit = !nt_q[AW-1] && (nt64_w >= det_w) && !nu_q[AW-1] && (nu_w <= det256_w);
  assign dist_sat = nt_w >= det256_w;

  // Hit coordinate: origin plus rounded unit * t / 2^14, clamped to the image.
  function automatic logic [HIT_W-1:0] hit_coord(input logic signed [ORG_W-1:0] o,
                                                 input logic signed [PW-1:0] p);
    logic [PW:0]            mag;
    logic [PW:0]            s;
    logic signed [PW+1:0]   h;
    mag = p[PW-1] ? (PW+1)'(-$signed({p[PW-1], p})) : {1'b0, p};
    s   = (mag + (PW+1)'(8192)) >> 14;
    h   = p[PW-1] ? ((PW+2)'(o) - $signed({1'b0, s}))
                  : ((PW+2)'(o) + $signed({1'b0, s}));
    if (h < 0) begin
      h = '0;
    end else if (h > $signed((PW+2)'(HMAX))) begin
      h = (PW+2)'(HMAX);
    end
    return h[HIT_W-1:0];
  endfunction

  assign in_fire  = in_i.valid && in_ready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = expect_first_q ? ST_L2A : ST_M0;
      ST_L2A:   state_d = ST_L2B;
      ST_L2B:   state_d = ST_SQI;
      ST_SQI:   state_d = (det_q == '0) ? ST_FDONE : ST_SQRT;
      ST_SQRT:  if (cnt_q == 6'd1) state_d = ST_NDX;
      ST_NDX:   state_d = ST_DIV;
      ST_NDY:   state_d = ST_DIV;
      ST_DIV:   if (cnt_q == 6'd1) state_d = ST_DFIN;
      ST_DFIN: begin
        case (dv_tgt_q)
          DIV_UX:  state_d = ST_NDY;
          DIV_UY:  state_d = ST_FDONE;
          default: state_d = ST_CMP;
        endcase
      end
      ST_FDONE: state_d = last_q ? ST_M0 : ST_IDLE;
      ST_M0:    state_d = ST_M1;
      ST_M1:    state_d = ST_M2;
      ST_M2:    state_d = ST_M3;
      ST_M3:    state_d = ST_M4;
      ST_M4:    state_d = ST_M5;
      ST_M5:    state_d = ST_NEG;
      ST_NEG:   state_d = (!dir_valid_q || det_q == '0) ? ST_EDONE : ST_TEST;
      ST_TEST: begin
        if (!edge_hit) state_d = ST_EDONE;
        else if (dist_sat) state_d = ST_CMP;
        else state_d = ST_DIV;
      end
      ST_CMP:   state_d = (!any_hit_q || t_q < best_dist_q) ? ST_HX : ST_EDONE;
      ST_HX:    state_d = ST_HXW;
      ST_HXW:   state_d = ST_HY;
      ST_HY:    state_d = ST_HYW;
      ST_HYW:   state_d = ST_EDONE;
      ST_EDONE: begin
        if (last_q && !closing_q) state_d = ST_M0;
        else if (last_q) state_d = ST_OUT;
        else state_d = ST_IDLE;
      end
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection.
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      ST_L2A: begin mul_a = MAW'(dx_q); mul_b = MBW'(dx_q); end
      ST_L2B: begin mul_a = MAW'(dy_q); mul_b = MBW'(dy_q); end
      ST_M0:  begin mul_a = MAW'(ey);   mul_b = MBW'(ux_q); end
      ST_M1:  begin mul_a = MAW'(ex);   mul_b = MBW'(uy_q); end
      ST_M2:  begin mul_a = MAW'(rx);   mul_b = MBW'(ey);   end
      ST_M3:  begin mul_a = MAW'(ry);   mul_b = MBW'(ex);   end
      ST_M4:  begin mul_a = MAW'(rx);   mul_b = MBW'(uy_q); end
      ST_M5:  begin mul_a = MAW'(ry);   mul_b = MBW'(ux_q); end
      ST_HX:  begin mul_a = $signed(MAW'(t_q)); mul_b = MBW'(ux_q); end
      ST_HY:  begin mul_a = $signed(MAW'(t_q)); mul_b = MBW'(uy_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.hit_x        = out_hx_q;
  assign out_o.hit_y        = out_hy_q;
  assign out_o.hit_distance = out_dist_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      expect_first_q <= 1'b1;
      out_valid_q    <= 1'b0;
      any_hit_q      <= 1'b0;
      dir_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q    <= 1'b1;
        expect_first_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && expect_first_q) begin
        expect_first_q <= 1'b0;
        any_hit_q      <= 1'b0;
        dir_valid_q    <= 1'b0;
      end
      if (state_q == ST_DFIN && dv_tgt_q == DIV_UY) dir_valid_q <= 1'b1;
      if (state_q == ST_HYW) any_hit_q <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          last_q <= in_i.last_vertex;
          if (expect_first_q) begin
            ox_q        <= in_i.origin_x;
            oy_q        <= in_i.origin_y;
            dx_q        <= in_i.dir_x;
            dy_q        <= in_i.dir_y;
            first_x_q   <= in_i.vertex_x;
            first_y_q   <= in_i.vertex_y;
            prev_x_q    <= in_i.vertex_x;
            prev_y_q    <= in_i.vertex_y;
            best_dist_q <= DIST_MAX;
            best_hx_q   <= '0;
            best_hy_q   <= '0;
            ux_q        <= '0;
            uy_q        <= '0;
            closing_q   <= 1'b0;
          end else begin
            ax_q      <= prev_x_q;
            ay_q      <= prev_y_q;
            bx_q      <= in_i.vertex_x;
            by_q      <= in_i.vertex_y;
            prev_x_q  <= in_i.vertex_x;
            prev_y_q  <= in_i.vertex_y;
            closing_q <= 1'b0;
          end
        end
      end
      ST_L2A: det_q <= prod_w;
      ST_L2B: det_q <= det_q + prod_w;
      ST_SQI: begin
        sq_s_q    <= {det_q[31:0], 28'h0};
        sq_root_q <= '0;
        sq_rem_q  <= '0;
        cnt_q     <= SQRT_STEPS;
      end
      ST_SQRT: begin
        sq_s_q    <= {sq_s_q[57:0], 2'b00};
        sq_rem_q  <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
        sq_root_q <= {sq_root_q[28:0], sq_ge};
        cnt_q     <= cnt_q - 6'd1;
      end
      ST_NDX: begin
        dv_rem_q <= DW'(nx_num[45:15]);
        dv_low_q <= {nx_num[14:0], 7'h00};
        dv_quo_q <= '0;
        dv_div_q <= AW'(sq_root_q);
        dv_tgt_q <= DIV_UX;
        cnt_q    <= NORM_QBITS;
      end
      ST_NDY: begin
        dv_rem_q <= DW'(ny_num[45:15]);
        dv_low_q <= {ny_num[14:0], 7'h00};
        dv_quo_q <= '0;
        dv_div_q <= AW'(sq_root_q);
        dv_tgt_q <= DIV_UY;
        cnt_q    <= NORM_QBITS;
      end
      ST_DIV: begin
        dv_rem_q <= dv_ge ? dv_sub : dv_rem_n;
        dv_low_q <= {dv_low_q[20:0], 1'b0};
        dv_quo_q <= {dv_quo_q[20:0], dv_ge};
        cnt_q    <= cnt_q - 6'd1;
      end
      ST_DFIN: begin
        case (dv_tgt_q)
          DIV_UX:  ux_q <= dx_q[DIR_W-1] ? -unit_pos : unit_pos;
          DIV_UY:  uy_q <= dy_q[DIR_W-1] ? -unit_pos : unit_pos;
          default: t_q  <= dv_quo_q;
        endcase
      end
      ST_FDONE, ST_EDONE: begin
        // Set up the edge that closes the polygon.
        if (last_q && !closing_q) begin
          ax_q      <= prev_x_q;
          ay_q      <= prev_y_q;
          bx_q      <= first_x_q;
          by_q      <= first_y_q;
          closing_q <= 1'b1;
        end
      end
      ST_M0: det_q <= prod_w;
      ST_M1: det_q <= det_q - prod_w;
      ST_M2: nt_q  <= prod_w;
      ST_M3: nt_q  <= nt_q - prod_w;
      ST_M4: nu_q  <= prod_w;
      ST_M5: nu_q  <= nu_q - prod_w;
      ST_NEG: begin
        if (det_q[AW-1]) begin
          det_q <= -det_q;
          nt_q  <= -nt_q;
          nu_q  <= -nu_q;
        end
      end
      ST_TEST: begin
        if (dist_sat) begin
          t_q <= DIST_MAX;
        end else begin
          dv_rem_q <= DW'($unsigned(nt_q[AW-1:8]));
          dv_low_q <= {nt_q[7:0], 14'h0};
          dv_quo_q <= '0;
          dv_div_q <= $unsigned(det_q);
          dv_tgt_q <= DIV_DIST;
          cnt_q    <= DIST_QBITS;
        end
      end
      ST_HX:  p_q <= prod;
      ST_HXW: best_hx_q <= hit_coord(ox_q, p_q);
      ST_HY:  p_q <= prod;
      ST_HYW: begin
        best_hy_q   <= hit_coord(oy_q, p_q);
        best_dist_q <= t_q;
      end
      ST_OUT: begin
        if (out_load) begin
          out_found_q <= any_hit_q;
          out_hx_q    <= any_hit_q ? best_hx_q : '0;
          out_hy_q    <= any_hit_q ? best_hy_q : '0;
          out_dist_q  <= any_hit_q ? best_dist_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/rpfh_checker.sv
module rpfh_checker import rpfh_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              found_i,
  input logic [HIT_W-1:0]  hit_x_i,
  input logic [HIT_W-1:0]  hit_y_i,
  input logic [DIST_W-1:0] hit_distance_i
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // The block is busy right after it takes a vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("vertex taken while busy");

  // A miss reports a zero point and distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> hit_x_i == '0 && hit_y_i == '0 && hit_distance_i == '0)
    else $error("miss with nonzero hit fields");

  // A hit lies at least one pixel out along the ray.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> hit_distance_i >= DIST_W'(256))
    else $error("hit closer than one pixel");

endmodule

bind ray_polygon_first_hit rpfh_checker u_rpfh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .found_i        (out_o.found),
  .hit_x_i        (out_o.hit_x),
  .hit_y_i        (out_o.hit_y),
  .hit_distance_i (out_o.hit_distance)
);
